// ----- design/pbrp_pkg.sv -----
`default_nettype none

package pbrp_pkg;

  localparam int unsigned CAP_W       = 11;
  localparam int unsigned VAR_W       = 64;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned OUT_DEPTH_D = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd256;

  localparam logic [6:0] VAR_MASK  = 7'h7F;
  localparam logic [3:0] VAR_MAXB  = 4'd10;
  localparam logic [2:0] TYPE_MASK = 3'h7;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADTYPE = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  typedef struct packed {
    logic                warn_en;
    logic [7:0]          wbyte;
    logic                wstart;
    logic                sum_en;
    logic [SCORE_W-1:0]  score;
    logic [1:0]          status;
  } bundle_t;

endpackage

`default_nettype wire

// ----- design/pbrp_parser.sv -----
`default_nettype none

module pbrp_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pbrp_pkg::CAP_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last,
  input  wire logic                          q_full,
  output logic                               push,
  output pbrp_pkg::bundle_t                  push_data
);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VARSKIP = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_SCORE   = 3'd3;
  localparam logic [2:0] PH_SKIPN   = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_HALT    = 3'd6;

  localparam int unsigned VW = pbrp_pkg::VAR_W;
  localparam int unsigned SW = pbrp_pkg::SCORE_W;
  localparam int unsigned CW = pbrp_pkg::CAP_W;

  logic [CW-1:0] cap_r;
  logic          in_vld_r;
  logic [7:0]    byte_r;
  logic          last_r;

  logic [2:0]    ph_r, ph_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] hold_r, hold_nxt;
  logic [SW-1:0] asm_r, asm_nxt;
  logic [CW-1:0] wemit_r, wemit_nxt;
  logic          err_r, err_nxt;

  logic          fire;
  logic [6:0]    shift;
  logic [VW-1:0] acc_fed;
  logic [3:0]    cnt_inc;
  logic          done;
  logic [31:0]   field;
  logic [2:0]    wt;
  logic [VW-1:0] rem_dec;
  logic [1:0]    k;
  logic [SW-1:0] asm_new;
  logic          emit;
  logic [1:0]    status;

  assign fire     = in_vld_r && !q_full;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= pbrp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  assign shift   = {cnt_r, 3'b000} - {3'b000, cnt_r};
  assign acc_fed = shift[6] ? acc_r
                            : (acc_r | (VW'(byte_r[6:0] & pbrp_pkg::VAR_MASK) << shift[5:0]));
  assign cnt_inc = cnt_r + 4'd1;
  assign done    = !byte_r[7] || (cnt_inc >= pbrp_pkg::VAR_MAXB);
  assign field   = acc_fed[34:3];
  assign wt      = acc_fed[2:0] & pbrp_pkg::TYPE_MASK;
  assign rem_dec = rem_r - VW'(1);
  assign k       = 2'd0 - rem_r[1:0];
  assign asm_new = asm_r | (SW'(byte_r) << {k, 3'b000});
  assign emit    = (cap_r != '0) && (({1'b0, wemit_r} + (CW+1)'(1)) < {1'b0, cap_r});

  always_comb begin
    ph_nxt    = ph_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    rem_nxt   = rem_r;
    hold_nxt  = hold_r;
    asm_nxt   = asm_r;
    wemit_nxt = wemit_r;
    err_nxt   = err_r;
    push_data = '0;
    case (ph_r)
      PH_TAG: begin
        if (done) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (field == 32'd1) begin
            if (wt == pbrp_pkg::WT_FIX32) begin
              hold_nxt = '0;
              asm_nxt  = '0;
              rem_nxt  = VW'(4);
              ph_nxt   = PH_SCORE;
            end
          end else if (field == 32'd2) begin
            if (wt == pbrp_pkg::WT_LEN) begin
              pend_nxt = 1'b1;
              ph_nxt   = PH_LEN;
            end
          end else begin
            case (wt)
              pbrp_pkg::WT_VARINT: ph_nxt = PH_VARSKIP;
              pbrp_pkg::WT_FIX64: begin
                rem_nxt = VW'(8);
                ph_nxt  = PH_SKIPN;
              end
              pbrp_pkg::WT_LEN: begin
                pend_nxt = 1'b0;
                ph_nxt   = PH_LEN;
              end
              pbrp_pkg::WT_FIX32: begin
                rem_nxt = VW'(4);
                ph_nxt  = PH_SKIPN;
              end
              default: begin
                err_nxt = 1'b1;
                ph_nxt  = PH_HALT;
              end
            endcase
          end
        end else begin
          acc_nxt = acc_fed;
          cnt_nxt = cnt_inc;
        end
      end
      PH_VARSKIP: begin
        if (done) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = PH_TAG;
        end else begin
          acc_nxt = acc_fed;
          cnt_nxt = cnt_inc;
        end
      end
      PH_LEN: begin
        if (done) begin
          rem_nxt   = acc_fed;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          wemit_nxt = '0;
          if (acc_fed == '0) begin
            ph_nxt = PH_TAG;
          end else begin
            ph_nxt = pend_r ? PH_BODY : PH_SKIPN;
          end
        end else begin
          acc_nxt = acc_fed;
          cnt_nxt = cnt_inc;
        end
      end
      PH_SCORE: begin
        asm_nxt = asm_new;
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          hold_nxt = asm_new;
          ph_nxt   = PH_TAG;
        end
      end
      PH_SKIPN: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          ph_nxt = PH_TAG;
        end
      end
      PH_BODY: begin
        if (emit) begin
          push_data.warn_en = 1'b1;
          push_data.wbyte   = byte_r;
          push_data.wstart  = (wemit_r == '0);
          wemit_nxt         = wemit_r + CW'(1);
        end
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          ph_nxt = PH_TAG;
        end
      end
      default: begin
      end
    endcase

    if (err_nxt) begin
      status = pbrp_pkg::ST_BADTYPE;
    end else if (ph_nxt != PH_TAG || cnt_nxt != '0) begin
      status = pbrp_pkg::ST_TRUNC;
    end else begin
      status = pbrp_pkg::ST_OK;
    end

    if (last_r) begin
      push_data.sum_en = 1'b1;
      push_data.score  = hold_nxt;
      push_data.status = status;
      ph_nxt    = PH_TAG;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      pend_nxt  = 1'b0;
      rem_nxt   = '0;
      hold_nxt  = '0;
      asm_nxt   = '0;
      wemit_nxt = '0;
      err_nxt   = 1'b0;
    end
  end

  assign push = fire && (push_data.warn_en || push_data.sum_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_TAG;
      acc_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
      hold_r  <= '0;
      asm_r   <= '0;
      wemit_r <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      ph_r    <= ph_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      hold_r  <= hold_nxt;
      asm_r   <= asm_nxt;
      wemit_r <= wemit_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/pbrp_out_queue.sv -----
`default_nettype none

module pbrp_out_queue #(
  parameter int unsigned DEPTH = pbrp_pkg::OUT_DEPTH_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire pbrp_pkg::bundle_t             push_data,
  output logic                               full,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_is_summary,
  output logic [7:0]                         out_warn_byte,
  output logic                               out_warn_start,
  output logic [pbrp_pkg::SCORE_W-1:0]       out_score_bits,
  output logic [1:0]                         out_status,
  output logic                               out_last_of_run
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  pbrp_pkg::bundle_t mem_r [DEPTH];
  logic [IW-1:0] wptr_r;
  logic [IW-1:0] rptr_r;
  logic [NW-1:0] count_r;
  logic          sent_warn_r;

  pbrp_pkg::bundle_t head;
  logic              show_sum;
  logic              xfer;
  logic              pop;

  assign head      = mem_r[rptr_r];
  assign full      = (count_r == NW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign show_sum  = !head.warn_en || sent_warn_r;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && (show_sum || !head.sum_en);

  assign out_is_summary  = show_sum;
  assign out_warn_byte   = show_sum ? 8'd0 : head.wbyte;
  assign out_warn_start  = show_sum ? 1'b0 : head.wstart;
  assign out_score_bits  = show_sum ? head.score : '0;
  assign out_status      = show_sum ? head.status : pbrp_pkg::ST_OK;
  assign out_last_of_run = show_sum || !head.sum_en;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      count_r     <= '0;
      sent_warn_r <= 1'b0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == IW'(DEPTH - 1)) ? '0 : wptr_r + IW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == IW'(DEPTH - 1)) ? '0 : rptr_r + IW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
      if (pop) begin
        sent_warn_r <= 1'b0;
      end else if (xfer) begin
        sent_warn_r <= 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full result queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("result queue count out of range");

  a_sent_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    sent_warn_r |-> (out_valid && head.warn_en && head.sum_en))
    else $error("half-sent entry without a pending summary");

  a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !out_is_summary && !out_last_of_run) |=> (out_valid && out_is_summary))
    else $error("summary does not follow its warning byte");

endmodule

`default_nettype wire

// ----- design/protobuf_response_parser.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_ready    | in_data_byte, in_last
// out      | out_valid / out_ready  | out_is_summary, out_warn_byte, out_warn_start,
//          |                        | out_score_bits, out_status, out_last_of_run
// cfg      | cfg_we                 | cfg_wdata (warning capacity)
//
// One byte per cycle unless stalled: a byte sits in the input register while the parser
// state and its results are computed, then the results go to the result queue.
// Results leave one per cycle while out_ready is high; a warning byte precedes its summary.
// Reset (rst_n low, synchronous) restores capacity 256 and the tag-expecting state.
// A full result queue stalls the input register; in_ready does not depend on out_ready.
`default_nettype none

module protobuf_response_parser #(
  parameter int unsigned OUT_DEPTH = pbrp_pkg::OUT_DEPTH_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pbrp_pkg::CAP_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_is_summary,
  output logic [7:0]                         out_warn_byte,
  output logic                               out_warn_start,
  output logic [pbrp_pkg::SCORE_W-1:0]       out_score_bits,
  output logic [1:0]                         out_status,
  output logic                               out_last_of_run
);

  logic              q_full;
  logic              push;
  pbrp_pkg::bundle_t push_data;

  pbrp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  pbrp_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_data       (push_data),
    .full            (q_full),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_summary  (out_is_summary),
    .out_warn_byte   (out_warn_byte),
    .out_warn_start  (out_warn_start),
    .out_score_bits  (out_score_bits),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
